[hw/rtl/slp_attribute_list_parser_defines.svh]
// ----------------------------------------------------------------------------
// slp attribute list parser assertion macros
// shared concurrent assertion forms used by the parser rtl
// ----------------------------------------------------------------------------
`ifndef SLP_ATTRIBUTE_LIST_PARSER_DEFINES_SVH
`define SLP_ATTRIBUTE_LIST_PARSER_DEFINES_SVH

// same-cycle implication
`define SLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/slp_pkg.sv]
// ----------------------------------------------------------------------------
// slp_pkg
// types, attribute name tables and character helpers for the attribute parser
// ----------------------------------------------------------------------------
package slp_pkg;

  localparam int NAMED_ATTRS  = 6;
  localparam int NUM_ATTRS_DEF = 6;
  localparam int NAME_CHARS   = 18;
  localparam int NAME_BITS    = NAME_CHARS * 8;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_END    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_MISSING = 3'd2,
    ST_MULTI   = 3'd3,
    ST_ESCAPE  = 3'd4,
    ST_UNTERM  = 3'd5
  } status_t;

  typedef struct packed {
    kind_t                  kind;
    logic [2:0]             attr_index;
    logic [7:0]             value_byte;
    status_t                status;
    logic [NAMED_ATTRS-1:0] missing_mask;
    logic                   is_final;
  } result_t;

  typedef struct packed {
    logic    v1;
    logic    v0;
    result_t r1;
    result_t r0;
  } res_pair_t;

  // names right-justified, first character in the highest used byte
  localparam logic [NAME_BITS-1:0] ATTR_NAME [NAMED_ATTRS] = '{
    NAME_BITS'("acn-fctn"),
    NAME_BITS'("acn-services"),
    NAME_BITS'("acn-uacn"),
    NAME_BITS'("cid"),
    NAME_BITS'("csl-esta.dmp"),
    NAME_BITS'("device-description")
  };

  localparam logic [4:0] ATTR_LEN [NAMED_ATTRS] = '{
    5'd8, 5'd12, 5'd8, 5'd3, 5'd12, 5'd18
  };

  // list-valued attributes: services, csl, device description
  localparam logic [NAMED_ATTRS-1:0] ATTR_LIST = 6'b110010;

  function automatic logic [7:0] attr_char(input logic [2:0] idx, input logic [4:0] pos);
    logic [NAME_BITS-1:0] nm;
    int sh;
    nm = ATTR_NAME[idx];
    sh = (int'(ATTR_LEN[idx]) - 1 - int'(pos)) * 8;
    if (sh < 0) begin
      return 8'h00;
    end
    return 8'(nm >> sh);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_class(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_reserved(input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (c < 8'h20 || c == 8'h7F) begin
      r = 1'b1;
    end else begin
      unique case (c)
        8'h28, 8'h29, 8'h2C, 8'h5C, 8'h21, 8'h3C, 8'h3D, 8'h3E, 8'h7E: r = 1'b1;
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

[hw/rtl/slp_parse.sv]
// ----------------------------------------------------------------------------
// slp_parse
// per-byte tag matching, value decoding and status tracking
// ----------------------------------------------------------------------------
`include "slp_attribute_list_parser_defines.svh"

module slp_parse
  import slp_pkg::*;
#(
  parameter int NUM_ATTRS = NUM_ATTRS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output res_pair_t  res
);

  localparam int ACTIVE_ATTRS = (NUM_ATTRS < NAMED_ATTRS) ? NUM_ATTRS : NAMED_ATTRS;
  localparam logic [NAMED_ATTRS-1:0] ACTIVE_MASK = NAMED_ATTRS'((1 << ACTIVE_ATTRS) - 1);

  typedef enum logic [2:0] {
    MODE_OUTSIDE = 3'd0,
    MODE_TAG     = 3'd1,
    MODE_VALUE   = 3'd2,
    MODE_ESC1    = 3'd3,
    MODE_ESC2    = 3'd4
  } mode_t;

  mode_t                  mode, mode_step, mode_next;
  logic [NAMED_ATTRS-1:0] cand, cand_step, cand_next;
  logic [4:0]             pos, pos_step, pos_next;
  logic [2:0]             cur, cur_step, cur_next;
  logic [NAMED_ATTRS-1:0] seen, seen_step, seen_next;
  logic [3:0]             hi, hi_step, hi_next;
  status_t                err, err_step, err_next;

  logic [7:0]             lc;
  logic [NAMED_ATTRS-1:0] tag_keep;
  logic                   hit_any;
  logic [2:0]             hit_idx;
  logic [4:0]             hx;
  logic [7:0]             dec;
  logic                   err_set;
  status_t                err_code;
  logic                   body_v;
  kind_t                  body_kind;
  logic [7:0]             body_val;
  logic [NAMED_ATTRS-1:0] miss;
  status_t                fin_status;
  result_t                body_r, fin_r;

  assign lc  = (in_byte >= 8'h41 && in_byte <= 8'h5A) ? 8'(in_byte + 8'd32) : in_byte;
  assign hx  = hex_class(in_byte);
  assign dec = {hi, hx[3:0]};

  always_comb begin
    for (int i = 0; i < NAMED_ATTRS; i++) begin
      tag_keep[i] = (pos < ATTR_LEN[i]) && (attr_char(3'(i), pos) == lc);
    end
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = 3'd0;
    for (int i = 0; i < ACTIVE_ATTRS; i++) begin
      if (cand[i] && ATTR_LEN[i] == pos) begin
        hit_any = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  always_comb begin
    mode_step = mode;
    cand_step = cand;
    pos_step  = pos;
    cur_step  = cur;
    seen_step = seen;
    hi_step   = hi;
    err_set   = 1'b0;
    err_code  = ST_OK;
    body_v    = 1'b0;
    body_kind = KIND_VALUE;
    body_val  = 8'h00;
    unique case (mode)
      MODE_TAG: begin
        if (in_byte == CH_LPAREN) begin
          cand_step = '1;
          pos_step  = '0;
        end else if (in_byte == CH_EQUAL) begin
          if (!hit_any) begin
            mode_step = MODE_OUTSIDE;
          end else if (seen[hit_idx]) begin
            err_set   = 1'b1;
            err_code  = ST_DUP;
            mode_step = MODE_OUTSIDE;
          end else begin
            seen_step[hit_idx] = 1'b1;
            cur_step  = hit_idx;
            mode_step = MODE_VALUE;
          end
        end else if (in_byte == CH_RPAREN) begin
          mode_step = MODE_OUTSIDE;
        end else begin
          cand_step = cand & tag_keep;
          if (pos != '1) begin
            pos_step = pos + 5'd1;
          end
        end
      end
      MODE_VALUE: begin
        if (in_byte == CH_RPAREN) begin
          body_v    = (err == ST_OK);
          body_kind = KIND_END;
          mode_step = MODE_OUTSIDE;
        end else if (in_byte == CH_COMMA) begin
          if (ATTR_LIST[cur]) begin
            body_v    = (err == ST_OK);
            body_kind = KIND_END;
          end else begin
            err_set  = 1'b1;
            err_code = ST_MULTI;
          end
        end else if (in_byte == CH_BSLASH) begin
          mode_step = MODE_ESC1;
        end else begin
          body_v   = (err == ST_OK);
          body_val = in_byte;
        end
      end
      MODE_ESC1: begin
        if (hx[4]) begin
          hi_step   = hx[3:0];
          mode_step = MODE_ESC2;
        end else begin
          err_set   = 1'b1;
          err_code  = ST_ESCAPE;
          mode_step = MODE_VALUE;
        end
      end
      MODE_ESC2: begin
        mode_step = MODE_VALUE;
        if (hx[4] && is_reserved(dec)) begin
          body_v   = (err == ST_OK);
          body_val = dec;
        end else begin
          err_set  = 1'b1;
          err_code = ST_ESCAPE;
        end
      end
      default: begin
        if (in_byte == CH_LPAREN) begin
          mode_step = MODE_TAG;
          cand_step = '1;
          pos_step  = '0;
        end else begin
          mode_step = MODE_OUTSIDE;
        end
      end
    endcase
    err_step = (err_set && err == ST_OK) ? err_code : err;
  end

  // final status priority: sticky error, unterminated, missing
  always_comb begin
    miss = ~seen_step & ACTIVE_MASK;
    priority if (err_step != ST_OK) begin
      fin_status = err_step;
    end else if (mode_step != MODE_OUTSIDE) begin
      fin_status = ST_UNTERM;
    end else if (miss != '0) begin
      fin_status = ST_MISSING;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_comb begin
    body_r.kind         = body_kind;
    body_r.attr_index   = cur;
    body_r.value_byte   = body_val;
    body_r.status       = ST_OK;
    body_r.missing_mask = '0;
    body_r.is_final     = 1'b0;
    fin_r.kind          = KIND_STATUS;
    fin_r.attr_index    = 3'd0;
    fin_r.value_byte    = 8'h00;
    fin_r.status        = fin_status;
    fin_r.missing_mask  = miss;
    fin_r.is_final      = 1'b1;
    res.v0 = in_valid && (body_v || in_last);
    res.v1 = in_valid && body_v && in_last;
    res.r0 = body_v ? body_r : fin_r;
    res.r1 = fin_r;
  end

  always_comb begin
    if (in_last) begin
      mode_next = MODE_OUTSIDE;
      cand_next = '1;
      pos_next  = '0;
      cur_next  = '0;
      seen_next = '0;
      hi_next   = '0;
      err_next  = ST_OK;
    end else begin
      mode_next = mode_step;
      cand_next = cand_step;
      pos_next  = pos_step;
      cur_next  = cur_step;
      seen_next = seen_step;
      hi_next   = hi_step;
      err_next  = err_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_OUTSIDE;
      cand <= '1;
      pos  <= '0;
      cur  <= '0;
      seen <= '0;
      hi   <= '0;
      err  <= ST_OK;
    end else if (in_valid) begin
      mode <= mode_next;
      cand <= cand_next;
      pos  <= pos_next;
      cur  <= cur_next;
      seen <= seen_next;
      hi   <= hi_next;
      err  <= err_next;
    end
  end

  `SLP_ASSERT_NEXT(a_clear_after_last, clk, rst, in_valid && in_last, mode == MODE_OUTSIDE && seen == '0 && err == ST_OK && cand == '1, "state not cleared after final byte")
  `SLP_ASSERT_NEXT(a_error_sticky, clk, rst, err != ST_OK && !(in_valid && in_last), err == $past(err), "sticky error changed within a string")
  `SLP_ASSERT_NOW(a_slot_order, clk, rst, res.v1, res.v0 && res.r1.is_final && !res.r0.is_final, "second result slot is not the final status")
  `SLP_ASSERT_NOW(a_value_needs_ok, clk, rst, res.v0 && !res.r0.is_final, err == ST_OK && (mode == MODE_VALUE || mode == MODE_ESC2), "value output outside a clean value")

endmodule

[hw/rtl/slp_out_fifo.sv]
// ----------------------------------------------------------------------------
// slp_out_fifo
// small result queue taking up to two words per cycle and giving one per cycle while out_ready is high
// ----------------------------------------------------------------------------
module slp_out_fifo
  import slp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t res,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_data
);

  result_t              mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr, rd;
  logic [OUT_CNT_W-1:0] cnt, cnt_next;
  logic [OUT_CNT_W-1:0] push_n;
  logic                 pop;

  assign push_n    = OUT_CNT_W'(res.v0) + OUT_CNT_W'(res.v1);
  assign out_valid = (cnt != '0);
  assign out_data  = mem[rd];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign cnt_next  = cnt + push_n - OUT_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (res.v0) begin
      mem[wr] <= res.r0;
    end
    if (res.v1) begin
      mem[wr + OUT_PTR_W'(1)] <= res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      wr  <= wr + OUT_PTR_W'(push_n);
      rd  <= rd + OUT_PTR_W'(pop);
      cnt <= cnt_next;
    end
  end

endmodule

[hw/rtl/slp_attribute_list_parser.sv]
// results of an accepted byte are registered in the four-word output queue, then output
// throughput: one byte per cycle while s_axis_tready is high; a final byte gives up to two
// words, drained one per m_axis_tready cycle; input stalls with under two free or in rst
// reset: synchronous rst returns the parser to the outside-attribute state and empties
// the queue, ready again in the next cycle
// ----------------------------------------------------------------------------
// slp_attribute_list_parser
// streaming attribute list parser with tagged value bytes and final status
// ----------------------------------------------------------------------------
module slp_attribute_list_parser
  import slp_pkg::*;
#(
  parameter int NUM_ATTRS = NUM_ATTRS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // attr_index, value_byte, status, missing_mask
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // is_final
);

  logic      accept;
  logic      room;
  res_pair_t res;
  result_t   out_word;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room && !rst;

  slp_parse #(
    .NUM_ATTRS(NUM_ATTRS)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_valid(accept),
    .in_byte (s_axis_tdata),
    .in_last (s_axis_tlast),
    .res     (res)
  );

  slp_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .room     (room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_word)
  );

  assign m_axis_tdata = {4'b0000, out_word.missing_mask, out_word.status,
                         out_word.value_byte, out_word.attr_index};
  assign m_axis_tuser = out_word.kind;
  assign m_axis_tlast = out_word.is_final;

endmodule
